// ----- hw/rtl/bsl_pkg.sv -----
// Shared constants, request codes and control structs for the bounded shift list.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package bsl_pkg;

    // List geometry.
    localparam int CAPACITY     = 256;
    localparam int ENTRY_W      = 24;
    localparam int COUNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int REQ_W        = 3;
    localparam int READ_INDEX_W = 8;
    localparam int CMP_W        = (COUNT_W > READ_INDEX_W) ? COUNT_W : READ_INDEX_W;

    // Registered reduction tree: cells are OR-ed in groups, then groups are OR-ed.
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    // Stream packing.
    localparam int S_TDATA_BITS = ENTRY_W + READ_INDEX_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W    = REQ_W;
    localparam int M_TDATA_BITS = COUNT_W + 3 * ENTRY_W;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W    = 2;

    localparam int M_HEAD_LSB  = COUNT_W;
    localparam int M_TAIL_LSB  = COUNT_W + ENTRY_W;
    localparam int M_READ_LSB  = COUNT_W + 2 * ENTRY_W;
    localparam int M_EMPTY_BIT = 0;
    localparam int M_REJ_BIT   = 1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REM_HEAD = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_TAIL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;

    // Update command broadcast to every cell on an accepted request.
    typedef struct packed {
        logic               shift_up;
        logic               shift_down;
        logic               wr_tail;
        logic [IDX_W-1:0]   wr_pos;
        logic [ENTRY_W-1:0] entry;
    } bsl_cmd_t;

    // Positions that the cells compare against for the tail and read lookups.
    typedef struct packed {
        logic [IDX_W-1:0] tail_pos;
        logic [IDX_W-1:0] read_pos;
    } bsl_sel_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bsl_cell.sv -----
// One storage cell of the bounded shift list: holds one entry and trades it with
// its neighbors on head inserts and removals. Depends on bsl_pkg.
`default_nettype none

module bsl_cell (
    input  wire logic                          aclk,
    input  wire bsl_pkg::bsl_cmd_t             cmd,
    input  wire bsl_pkg::bsl_sel_t             sel,
    input  wire logic [bsl_pkg::IDX_W-1:0]     cell_index,
    input  wire logic [bsl_pkg::ENTRY_W-1:0]   below_data,
    input  wire logic [bsl_pkg::ENTRY_W-1:0]   above_data,
    output logic      [bsl_pkg::ENTRY_W-1:0]   data,
    output logic      [bsl_pkg::ENTRY_W-1:0]   tail_data,
    output logic      [bsl_pkg::ENTRY_W-1:0]   read_data
);

    logic [bsl_pkg::ENTRY_W-1:0] data_reg;
    logic [bsl_pkg::ENTRY_W-1:0] data_next;

    // A head insert pulls from below, a head removal pulls from above,
    // and a tail insert writes only the cell at the current count.
    always_comb begin
        data_next = data_reg;
        if (cmd.shift_up) begin
            data_next = below_data;
        end else if (cmd.shift_down) begin
            data_next = above_data;
        end else if (cmd.wr_tail && (cmd.wr_pos == cell_index)) begin
            data_next = cmd.entry;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // Each cell drives its entry into the reduction trees only when selected.
    assign data      = data_reg;
    assign tail_data = (sel.tail_pos == cell_index) ? data_reg : '0;
    assign read_data = (sel.read_pos == cell_index) ? data_reg : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_shift_list_unit.sv -----
// Top level of the bounded shift list: request decode, count, the row of cells
// and the registered tail/read lookup. Depends on bsl_pkg and bsl_cell.
//
// The block keeps up to CAPACITY entries in a row of cells that all shift at
// once on a head insert or head removal. Each request on the slave stream
// yields exactly one result on the master stream: the cells update in the
// accept cycle, a first register stage ORs the selected tail and read entries
// within groups of GROUP_SIZE cells, and a second stage ORs the groups into
// the output register. A new request is taken once the lookup of the previous
// one is done, so the block accepts one request at a time; a result may sit
// in the output register while the next request is already at work. Reset
// clears the state, the count and the output valid only; cell contents are
// not cleared, and only cells below the count are ever reported.
`default_nettype none

module bounded_shift_list_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: entry_in, read_index (lowest bit up)
    input  wire logic [bsl_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: req_type
    input  wire logic [bsl_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: count, head_entry, tail_entry, read_entry (lowest bit up)
    output logic      [bsl_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: is_empty, rejected (lowest bit up)
    output logic      [bsl_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_GATHER = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [bsl_pkg::COUNT_W-1:0] count_reg;
    logic [bsl_pkg::COUNT_W-1:0] count_next;
    logic                        rej_reg;
    logic                        rej_next;
    bsl_pkg::bsl_sel_t           sel_reg;
    bsl_pkg::bsl_sel_t           sel_next;
    bsl_pkg::bsl_cmd_t           cmd;

    logic [bsl_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [bsl_pkg::M_TDATA_W-1:0] m_tdata_next;
    logic [bsl_pkg::M_TUSER_W-1:0] m_tuser_reg;
    logic [bsl_pkg::M_TUSER_W-1:0] m_tuser_next;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;

    logic [bsl_pkg::REQ_W-1:0]        req_type;
    logic [bsl_pkg::ENTRY_W-1:0]      entry_in;
    logic [bsl_pkg::READ_INDEX_W-1:0] read_index;

    logic in_accept;
    logic out_load;
    logic is_ins;
    logic is_rem;
    logic is_full;
    logic is_empty_now;

    logic [bsl_pkg::COUNT_W-1:0] last_full;
    logic [bsl_pkg::CMP_W-1:0]   last_ext;
    logic [bsl_pkg::CMP_W-1:0]   ridx_ext;
    logic [bsl_pkg::CMP_W-1:0]   pos_ext;

    logic [bsl_pkg::ENTRY_W-1:0] cell_data [bsl_pkg::CAPACITY];
    logic [bsl_pkg::ENTRY_W-1:0] cell_tail [bsl_pkg::CAPACITY];
    logic [bsl_pkg::ENTRY_W-1:0] cell_read [bsl_pkg::CAPACITY];

    logic [bsl_pkg::ENTRY_W-1:0] grp_tail_next [bsl_pkg::NUM_GROUPS];
    logic [bsl_pkg::ENTRY_W-1:0] grp_read_next [bsl_pkg::NUM_GROUPS];
    logic [bsl_pkg::ENTRY_W-1:0] grp_tail_reg  [bsl_pkg::NUM_GROUPS];
    logic [bsl_pkg::ENTRY_W-1:0] grp_read_reg  [bsl_pkg::NUM_GROUPS];

    logic [bsl_pkg::ENTRY_W-1:0] tail_sum;
    logic [bsl_pkg::ENTRY_W-1:0] read_sum;
    logic [bsl_pkg::ENTRY_W-1:0] head_out;
    logic [bsl_pkg::ENTRY_W-1:0] tail_out;
    logic [bsl_pkg::ENTRY_W-1:0] read_out;
    logic                        res_empty;

    // Unpack the request transaction.
    assign req_type   = s_tuser[bsl_pkg::REQ_W-1:0];
    assign entry_in   = s_tdata[bsl_pkg::ENTRY_W-1:0];
    assign read_index = s_tdata[bsl_pkg::ENTRY_W +: bsl_pkg::READ_INDEX_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);

    // Decode the request and work out the new count and rejection.
    always_comb begin
        is_ins = 1'b0;
        is_rem = 1'b0;
        unique case (req_type) inside
            bsl_pkg::REQ_INS_HEAD,
            bsl_pkg::REQ_INS_TAIL: is_ins = 1'b1;
            bsl_pkg::REQ_REM_HEAD,
            bsl_pkg::REQ_REM_TAIL: is_rem = 1'b1;
            default: begin
                is_ins = 1'b0;
                is_rem = 1'b0;
            end
        endcase
    end

    assign is_full      = (count_reg == bsl_pkg::COUNT_W'(bsl_pkg::CAPACITY));
    assign is_empty_now = (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        rej_next   = rej_reg;
        if (in_accept) begin
            rej_next = (is_ins && is_full) || (is_rem && is_empty_now);
            if (is_ins && !is_full) begin
                count_next = count_reg + 1'b1;
            end else if (is_rem && !is_empty_now) begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    // Command to the cells; only a request that is not rejected moves data.
    always_comb begin
        cmd.shift_up   = in_accept && !is_full && (req_type == bsl_pkg::REQ_INS_HEAD);
        cmd.shift_down = in_accept && !is_empty_now && (req_type == bsl_pkg::REQ_REM_HEAD);
        cmd.wr_tail    = in_accept && !is_full && (req_type == bsl_pkg::REQ_INS_TAIL);
        cmd.wr_pos     = count_reg[bsl_pkg::IDX_W-1:0];
        cmd.entry      = entry_in;
    end

    // Tail and clamped read positions for the count after this request.
    always_comb begin
        last_full = count_next - 1'b1;
        last_ext  = bsl_pkg::CMP_W'(last_full);
        ridx_ext  = bsl_pkg::CMP_W'(read_index);
        pos_ext   = (ridx_ext > last_ext) ? last_ext : ridx_ext;
        sel_next  = sel_reg;
        if (in_accept) begin
            sel_next.tail_pos = last_full[bsl_pkg::IDX_W-1:0];
            sel_next.read_pos = pos_ext[bsl_pkg::IDX_W-1:0];
        end
    end

    // Row of cells; the bottom cell takes the new entry on a head insert.
    for (genvar k = 0; k < bsl_pkg::CAPACITY; k++) begin : g_cell
        logic [bsl_pkg::ENTRY_W-1:0] below;
        logic [bsl_pkg::ENTRY_W-1:0] above;
        if (k == 0) begin : g_bottom
            assign below = cmd.entry;
        end else begin : g_mid_lo
            assign below = cell_data[k-1];
        end
        if (k == bsl_pkg::CAPACITY - 1) begin : g_top
            assign above = '0;
        end else begin : g_mid_hi
            assign above = cell_data[k+1];
        end
        bsl_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .sel        (sel_reg),
            .cell_index (bsl_pkg::IDX_W'(k)),
            .below_data (below),
            .above_data (above),
            .data       (cell_data[k]),
            .tail_data  (cell_tail[k]),
            .read_data  (cell_read[k])
        );
    end

    // First reduction stage: OR the selected entries within each group.
    always_comb begin
        for (int g = 0; g < bsl_pkg::NUM_GROUPS; g++) begin
            grp_tail_next[g] = '0;
            grp_read_next[g] = '0;
            for (int i = 0; i < bsl_pkg::GROUP_SIZE; i++) begin
                if (g * bsl_pkg::GROUP_SIZE + i < bsl_pkg::CAPACITY) begin
                    grp_tail_next[g] = grp_tail_next[g]
                                     | cell_tail[g * bsl_pkg::GROUP_SIZE + i];
                    grp_read_next[g] = grp_read_next[g]
                                     | cell_read[g * bsl_pkg::GROUP_SIZE + i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_GATHER) begin
            for (int g = 0; g < bsl_pkg::NUM_GROUPS; g++) begin
                grp_tail_reg[g] <= grp_tail_next[g];
                grp_read_reg[g] <= grp_read_next[g];
            end
        end
    end

    // Second reduction stage: OR the groups and assemble the result transaction.
    always_comb begin
        tail_sum = '0;
        read_sum = '0;
        for (int g = 0; g < bsl_pkg::NUM_GROUPS; g++) begin
            tail_sum = tail_sum | grp_tail_reg[g];
            read_sum = read_sum | grp_read_reg[g];
        end
    end

    assign res_empty = (count_reg == '0);
    assign head_out  = res_empty ? '0 : cell_data[0];
    assign tail_out  = res_empty ? '0 : tail_sum;
    assign read_out  = res_empty ? '0 : read_sum;

    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tdata_next = bsl_pkg::M_TDATA_W'({read_out, tail_out, head_out, count_reg});
            m_tuser_next[bsl_pkg::M_EMPTY_BIT] = res_empty;
            m_tuser_next[bsl_pkg::M_REJ_BIT]   = rej_reg;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Sequencer: accept, gather groups, then hand the result to the output register.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rej_reg     <= rej_next;
        sel_reg     <= sel_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bsl_checker.sv -----
// Port-level checker for the bounded shift list and the bind that attaches it
// to bounded_shift_list_unit. Depends on bsl_pkg.
`default_nettype none

module bsl_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [bsl_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic [bsl_pkg::M_TUSER_W-1:0]   m_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready
);

    logic [bsl_pkg::COUNT_W-1:0]  res_count;
    logic [3*bsl_pkg::ENTRY_W-1:0] res_entries;

    assign res_count   = m_tdata[bsl_pkg::COUNT_W-1:0];
    assign res_entries = m_tdata[bsl_pkg::M_HEAD_LSB +: 3*bsl_pkg::ENTRY_W];

    // A stalled result transaction holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The empty flag agrees with the reported count.
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[bsl_pkg::M_EMPTY_BIT] == (res_count == '0)))
        else $error("empty flag disagrees with count");

    // An empty list reports zero head, tail and read entries.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[bsl_pkg::M_EMPTY_BIT] |-> (res_entries == '0))
        else $error("empty list reported a nonzero entry");

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_count <= bsl_pkg::COUNT_W'(bsl_pkg::CAPACITY)))
        else $error("count beyond capacity");

    // Ready drops after every accepted request, so requests are taken one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted in back-to-back cycles");

endmodule

bind bounded_shift_list_unit bsl_checker u_bsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the bounded shift list top level.
// Drives request transactions, predicts each result from its own list model or a fixed row,
// and compares them field by field; depends on bsl_pkg and bounded_shift_list_unit.
`timescale 1ns / 1ps

module tb;

    // Request codes the block treats as a plain read.
    localparam logic [bsl_pkg::REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
    localparam logic [bsl_pkg::REQ_W-1:0] REQ_SPARE_MID = 3'd6;
    localparam logic [bsl_pkg::REQ_W-1:0] REQ_SPARE_HI  = 3'd7;

    localparam int RANDOM_ITEMS   = 700;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLDOFF_AT     = 80;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int STEADY_FIRST   = 300;
    localparam int STEADY_LAST    = 450;
    localparam int PAUSE_AT       = 500;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        logic [bsl_pkg::COUNT_W-1:0] count;
        logic [bsl_pkg::ENTRY_W-1:0] head_entry;
        logic [bsl_pkg::ENTRY_W-1:0] tail_entry;
        logic [bsl_pkg::ENTRY_W-1:0] read_entry;
        logic                        is_empty;
        logic                        rejected;
    } list_result_t;

    typedef struct {
        logic [bsl_pkg::REQ_W-1:0]        req;
        logic [bsl_pkg::ENTRY_W-1:0]      entry;
        logic [bsl_pkg::READ_INDEX_W-1:0] index;
        bit                               fixed;
        list_result_t                     fixed_result;
    } request_row_t;

    typedef enum {TRAFFIC_BALANCED, TRAFFIC_FILL, TRAFFIC_DRAIN} traffic_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic [bsl_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [bsl_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [bsl_pkg::M_TDATA_W-1:0] m_tdata;
    logic [bsl_pkg::M_TUSER_W-1:0] m_tuser;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;

    // Shadow copy of the list contents and length.
    logic [bsl_pkg::ENTRY_W-1:0] shadow_cells [bsl_pkg::CAPACITY];
    int                          shadow_len = 0;

    list_result_t pending_results [$];
    request_row_t directed_rows [$];
    int           error_count   = 0;
    int           results_seen  = 0;
    int           stall_cycles  = 0;
    bit           steady        = 1'b0;
    bit           holdoff_done  = 1'b0;

    bounded_shift_list_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 aclk = ~aclk;

    // Apply one request to the shadow list and return the result it should report.
    function automatic list_result_t apply_request(logic [bsl_pkg::REQ_W-1:0] req,
                                                   logic [bsl_pkg::ENTRY_W-1:0] entry,
                                                   logic [bsl_pkg::READ_INDEX_W-1:0] index);
        list_result_t res;
        int           last;
        int           pos;
        res = '0;
        case (req)
            bsl_pkg::REQ_INS_HEAD: begin
                if (shadow_len == bsl_pkg::CAPACITY) begin
                    res.rejected = 1'b1;
                end else begin
                    for (int k = shadow_len; k > 0; k--) shadow_cells[k] = shadow_cells[k-1];
                    shadow_cells[0] = entry;
                    shadow_len++;
                end
            end
            bsl_pkg::REQ_INS_TAIL: begin
                if (shadow_len == bsl_pkg::CAPACITY) begin
                    res.rejected = 1'b1;
                end else begin
                    shadow_cells[shadow_len] = entry;
                    shadow_len++;
                end
            end
            bsl_pkg::REQ_REM_HEAD: begin
                if (shadow_len == 0) begin
                    res.rejected = 1'b1;
                end else begin
                    for (int k = 1; k < shadow_len; k++) shadow_cells[k-1] = shadow_cells[k];
                    shadow_len--;
                end
            end
            bsl_pkg::REQ_REM_TAIL: begin
                if (shadow_len == 0) res.rejected = 1'b1;
                else shadow_len--;
            end
            default: begin
            end
        endcase
        res.count    = shadow_len[bsl_pkg::COUNT_W-1:0];
        res.is_empty = (shadow_len == 0);
        if (shadow_len != 0) begin
            last           = shadow_len - 1;
            pos            = (int'(index) > last) ? last : int'(index);
            res.head_entry = shadow_cells[0];
            res.tail_entry = shadow_cells[last];
            res.read_entry = shadow_cells[pos];
        end
        return res;
    endfunction

    // Offer one request transaction; entered and left just after a falling edge.
    task automatic send_request(request_row_t row);
        list_result_t res;
        if (!steady) begin
            while ($urandom_range(99) < 23) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bsl_pkg::S_TDATA_W'({row.index, row.entry});
        s_tuser  <= row.req;
        do @(posedge aclk); while (!s_tready);
        res = apply_request(row.req, row.entry, row.index);
        pending_results.push_back(row.fixed ? row.fixed_result : res);
        @(negedge aclk);
    endtask

    // Stop offering requests until every outstanding result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
            error_count++;
        end
    endtask

    task automatic add_row(logic [bsl_pkg::REQ_W-1:0] req,
                           logic [bsl_pkg::ENTRY_W-1:0] entry,
                           logic [bsl_pkg::READ_INDEX_W-1:0] index, bit fixed,
                           logic [bsl_pkg::COUNT_W-1:0] count,
                           logic [bsl_pkg::ENTRY_W-1:0] head,
                           logic [bsl_pkg::ENTRY_W-1:0] tail,
                           logic [bsl_pkg::ENTRY_W-1:0] rd,
                           logic empty, logic rej);
        request_row_t row;
        row.req          = req;
        row.entry        = entry;
        row.index        = index;
        row.fixed        = fixed;
        row.fixed_result = '{count, head, tail, rd, empty, rej};
        directed_rows.push_back(row);
    endtask

    // Result side: compare every accepted result transaction with the oldest prediction.
    always @(posedge aclk) begin
        list_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result transaction arrived with no prediction pending");
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                check_field("count", 32'(exp_res.count),
                            32'(m_tdata[bsl_pkg::COUNT_W-1:0]));
                check_field("head_entry", 32'(exp_res.head_entry),
                            32'(m_tdata[bsl_pkg::M_HEAD_LSB +: bsl_pkg::ENTRY_W]));
                check_field("tail_entry", 32'(exp_res.tail_entry),
                            32'(m_tdata[bsl_pkg::M_TAIL_LSB +: bsl_pkg::ENTRY_W]));
                check_field("read_entry", 32'(exp_res.read_entry),
                            32'(m_tdata[bsl_pkg::M_READ_LSB +: bsl_pkg::ENTRY_W]));
                check_field("is_empty", 32'(exp_res.is_empty),
                            32'(m_tuser[bsl_pkg::M_EMPTY_BIT]));
                check_field("rejected", 32'(exp_res.rejected),
                            32'(m_tuser[bsl_pkg::M_REJ_BIT]));
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off that backs up the block.
    initial begin
        forever begin
            @(negedge aclk);
            if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        request_row_t row;
        traffic_t     traffic;
        traffic_t     next_bulk;
        int           phase_left;
        int           overshoot;
        int           pick;

        // Directed requests: empty-list rejections, extremes, clamping, spare codes.
        add_row(bsl_pkg::REQ_REM_HEAD, 24'h000000, 8'h00, 1, 9'd0,
                24'h0, 24'h0, 24'h0, 1, 1);
        add_row(bsl_pkg::REQ_REM_TAIL, 24'hFFFFFF, 8'hFF, 1, 9'd0,
                24'h0, 24'h0, 24'h0, 1, 1);
        add_row(bsl_pkg::REQ_READ,     24'hFFFFFF, 8'hFF, 1, 9'd0,
                24'h0, 24'h0, 24'h0, 1, 0);
        add_row(REQ_SPARE_HI,          24'h000000, 8'h00, 1, 9'd0,
                24'h0, 24'h0, 24'h0, 1, 0);
        add_row(bsl_pkg::REQ_INS_TAIL, 24'hFFFFFF, 8'h00, 1, 9'd1,
                24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
        add_row(bsl_pkg::REQ_INS_HEAD, 24'h000000, 8'hFF, 1, 9'd2,
                24'h000000, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
        add_row(bsl_pkg::REQ_INS_HEAD, 24'hA5A5A5, 8'h01, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_INS_TAIL, 24'h5A5A5A, 8'h03, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_READ,     24'h000000, 8'h00, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_READ,     24'h000000, 8'h02, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_READ,     24'h000000, 8'hC8, 0, '0, '0, '0, '0, 0, 0);
        add_row(REQ_SPARE_LO,          24'h123456, 8'h01, 0, '0, '0, '0, '0, 0, 0);
        add_row(REQ_SPARE_MID,         24'h654321, 8'h80, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_REM_HEAD, 24'h000000, 8'h00, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_REM_TAIL, 24'h000000, 8'hFF, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_INS_TAIL, 24'h800001, 8'h02, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_REM_HEAD, 24'h000000, 8'h01, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_REM_HEAD, 24'h000000, 8'h00, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_REM_TAIL, 24'h000000, 8'h00, 0, '0, '0, '0, '0, 0, 0);
        add_row(bsl_pkg::REQ_REM_TAIL, 24'h000000, 8'h00, 1, 9'd0,
                24'h0, 24'h0, 24'h0, 1, 1);
        add_row(bsl_pkg::REQ_INS_HEAD, 24'h7FFFFE, 8'h55, 1, 9'd1,
                24'h7FFFFE, 24'h7FFFFE, 24'h7FFFFE, 0, 0);
        add_row(bsl_pkg::REQ_REM_HEAD, 24'h000000, 8'hAA, 1, 9'd0,
                24'h0, 24'h0, 24'h0, 1, 0);

        // Synchronous reset, released just after a falling edge.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) send_request(directed_rows[i]);
        wait_for_results();

        // Random traffic: alternate bulk fills and drains so the list reaches both
        // full and empty, with balanced stretches in between.
        traffic    = TRAFFIC_BALANCED;
        next_bulk  = TRAFFIC_FILL;
        phase_left = 40;
        overshoot  = 0;
        row.fixed        = 1'b0;
        row.fixed_result = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= STEADY_FIRST) && (n < STEADY_LAST);
            if (n == PAUSE_AT) wait_for_results();

            pick = $urandom_range(99);
            if ((traffic == TRAFFIC_FILL && pick < 90) ||
                (traffic == TRAFFIC_DRAIN && pick >= 94) ||
                (traffic == TRAFFIC_BALANCED && pick < 30)) begin
                row.req = $urandom_range(1) ? bsl_pkg::REQ_INS_HEAD : bsl_pkg::REQ_INS_TAIL;
            end else if ((traffic == TRAFFIC_DRAIN && pick < 90) ||
                         (traffic == TRAFFIC_FILL && pick >= 94) ||
                         (traffic == TRAFFIC_BALANCED && pick < 60)) begin
                row.req = $urandom_range(1) ? bsl_pkg::REQ_REM_HEAD : bsl_pkg::REQ_REM_TAIL;
            end else begin
                row.req = ($urandom_range(3) == 0) ?
                          bsl_pkg::REQ_W'($urandom_range(7, 5)) : bsl_pkg::REQ_READ;
            end
            row.entry = bsl_pkg::ENTRY_W'($urandom());
            if ($urandom_range(1) == 0 || shadow_len == 0) begin
                row.index = bsl_pkg::READ_INDEX_W'($urandom_range(255));
            end else begin
                row.index = bsl_pkg::READ_INDEX_W'($urandom_range(shadow_len - 1));
            end
            send_request(row);

            // Advance the traffic pattern on the predicted list length.
            case (traffic)
                TRAFFIC_BALANCED: begin
                    phase_left--;
                    if (phase_left == 0) begin
                        traffic   = next_bulk;
                        next_bulk = (next_bulk == TRAFFIC_FILL) ? TRAFFIC_DRAIN : TRAFFIC_FILL;
                        overshoot = $urandom_range(10, 3);
                    end
                end
                default: begin
                    if ((traffic == TRAFFIC_FILL && shadow_len == bsl_pkg::CAPACITY) ||
                        (traffic == TRAFFIC_DRAIN && shadow_len == 0)) begin
                        if (overshoot == 0) begin
                            traffic    = TRAFFIC_BALANCED;
                            phase_left = $urandom_range(60, 20);
                        end else begin
                            overshoot--;
                        end
                    end
                end
            endcase
        end
        steady = 1'b0;

        // Drain the remaining results, then watch a little longer for stray ones.
        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
